@@ hw/rtl/yuv420_region_mosaic_assert.svh @@
// Assertion macros used by the checker file yrm_checker.sv.
// Every check is sampled on the rising edge of clk and is held off during reset.
`ifndef YUV420_REGION_MOSAIC_ASSERT_SVH
`define YUV420_REGION_MOSAIC_ASSERT_SVH

`define YRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define YRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/yrm_pkg.sv @@
// ----------------------------------------------------------------------------
// yrm_pkg
// Frame geometry, request codes, register indexes and address helpers shared
// by the mosaic modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package yrm_pkg;

  localparam int FRAME_WIDTH  = 800;
  localparam int FRAME_HEIGHT = 600;
  localparam int CHROMA_W     = FRAME_WIDTH / 2;
  localparam int CHROMA_H     = FRAME_HEIGHT / 2;
  localparam int LUMA_DEPTH   = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int CHROMA_DEPTH = CHROMA_W * CHROMA_H;
  localparam int LUMA_AW      = $clog2(LUMA_DEPTH);
  localparam int CHROMA_AW    = $clog2(CHROMA_DEPTH);

  localparam int COORD_W = 10;
  localparam int SUM_W   = 24;
  localparam int CNT_W   = 16;

  localparam logic [7:0] BORDER_LUMA = 8'd76;
  localparam logic [7:0] MIN_TILE    = 8'd2;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_RUN   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  localparam logic [1:0] PLANE_Y = 2'd0;
  localparam logic [1:0] PLANE_U = 2'd1;
  localparam logic [1:0] PLANE_V = 2'd2;

  localparam logic [2:0] CFG_REGION_X      = 3'd0;
  localparam logic [2:0] CFG_REGION_Y      = 3'd1;
  localparam logic [2:0] CFG_REGION_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_REGION_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_TILE_SIZE     = 3'd4;
  localparam logic [2:0] CFG_FRAME_BORDER  = 3'd5;
  localparam logic [2:0] CFG_MOSAIC_ENABLE = 3'd6;

  function automatic logic [LUMA_AW-1:0] luma_addr(input logic [COORD_W-1:0] r,
                                                   input logic [COORD_W-1:0] c);
    luma_addr = LUMA_AW'(r * FRAME_WIDTH + c);
  endfunction

  function automatic logic [CHROMA_AW-1:0] chroma_addr(input logic [COORD_W-1:0] r,
                                                       input logic [COORD_W-1:0] c);
    chroma_addr = CHROMA_AW'(r * CHROMA_W + c);
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/yuv420_region_mosaic.sv @@
// ----------------------------------------------------------------------------
// yuv420_region_mosaic
// Planar YUV420 frame store with a block-average mosaic over a region.
// ----------------------------------------------------------------------------
// A write or a request of an unknown type is answered from the idle state, a
// read from the read-wait state. A run with the mosaic enabled walks the
// clipped region tile by tile: for each luma tile and each non-empty U and V
// tile it reads every sample once (one per cycle on the plane's single read
// port), divides the sum in the shared bit-serial divider, then writes every
// sample once; the border is then written at one sample per cycle. The block
// takes no new word until the result word of the current one has been
// delivered.
`timescale 1ns / 1ps
`default_nettype none
module yuv420_region_mosaic
  import yrm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [1:0]   req_type,
  input  logic [1:0]   plane,
  input  logic [9:0]   row,
  input  logic [9:0]   col,
  input  logic [7:0]   sample,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [7:0]   read_sample,
  output logic         run_done,
  input  logic         cfg_wen,
  input  logic [2:0]   cfg_index,
  input  logic [9:0]   cfg_data
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RDW    = 4'd1;
  localparam logic [3:0] S_SETUP  = 4'd2;
  localparam logic [3:0] S_START  = 4'd3;
  localparam logic [3:0] S_TILE   = 4'd4;
  localparam logic [3:0] S_SUM    = 4'd5;
  localparam logic [3:0] S_SUMW   = 4'd6;
  localparam logic [3:0] S_DSTART = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_FILL   = 4'd9;
  localparam logic [3:0] S_NEXT   = 4'd10;
  localparam logic [3:0] S_BORD   = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  logic [9:0] region_x, region_y, region_width, region_height;
  logic [7:0] tile_size, frame_border;
  logic       mosaic_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_x      <= '0;
      region_y      <= '0;
      region_width  <= '0;
      region_height <= '0;
      tile_size     <= 8'd16;
      frame_border  <= '0;
      mosaic_enable <= 1'b0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_REGION_X:      region_x      <= cfg_data;
        CFG_REGION_Y:      region_y      <= cfg_data;
        CFG_REGION_WIDTH:  region_width  <= cfg_data;
        CFG_REGION_HEIGHT: region_height <= cfg_data;
        CFG_TILE_SIZE:     tile_size     <= cfg_data[7:0];
        CFG_FRAME_BORDER:  frame_border  <= cfg_data[7:0];
        CFG_MOSAIC_ENABLE: mosaic_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [3:0] state, state_next;

  // Clipped region, held for the whole run.
  logic [9:0] x_q, y_q, w_q, h_q, ex_q, ey_q;
  logic [7:0] b_q, t_q;
  logic [10:0] tx, ty;
  logic [1:0] job;
  logic       border_mode;

  // Current rectangle and its scan position.
  logic [1:0] pl;
  logic [9:0] rx0, ry0, rx1, ry1, r, c;
  logic       pend;
  logic [SUM_W-1:0] acc;
  logic [CNT_W-1:0] cnt;
  logic [7:0] mean;

  logic       rd_ok_q;
  logic [1:0] rd_pl_q;

  // Clipping from the live registers.
  logic [9:0] cx, cy, cw, ch, fw_left, fh_left, min_wh;
  assign cx      = (region_x > 10'(FRAME_WIDTH - 1)) ? 10'(FRAME_WIDTH - 1) : region_x;
  assign cy      = (region_y > 10'(FRAME_HEIGHT - 1)) ? 10'(FRAME_HEIGHT - 1) : region_y;
  assign fw_left = 10'(FRAME_WIDTH) - cx;
  assign fh_left = 10'(FRAME_HEIGHT) - cy;
  assign cw      = (region_width < fw_left) ? region_width : fw_left;
  assign ch      = (region_height < fh_left) ? region_height : fh_left;
  assign min_wh  = (w_q < h_q) ? w_q : h_q;

  // Tile ends and the chroma tile under the current luma tile.
  logic [10:0] tx_end, ty_end, ntx, nty;
  logic [9:0]  lx1, ly1, ux, uy, uex, uey, cex, cey;
  logic [10:0] ux_end, uy_end;
  logic        chroma_ok;
  assign tx_end = tx + 11'(b_q);
  assign ty_end = ty + 11'(b_q);
  assign lx1    = (tx_end < {1'b0, ex_q}) ? tx_end[9:0] : ex_q;
  assign ly1    = (ty_end < {1'b0, ey_q}) ? ty_end[9:0] : ey_q;
  assign ux     = {1'b0, tx[9:1]};
  assign uy     = {1'b0, ty[9:1]};
  assign cex    = {1'b0, ex_q[9:1]};
  assign cey    = {1'b0, ey_q[9:1]};
  assign ux_end = {1'b0, ux} + 11'(b_q[7:1]);
  assign uy_end = {1'b0, uy} + 11'(b_q[7:1]);
  assign uex    = (ux_end < {1'b0, cex}) ? ux_end[9:0] : cex;
  assign uey    = (uy_end < {1'b0, cey}) ? uy_end[9:0] : cey;
  assign chroma_ok = (uex > ux) && (uey > uy);
  assign ntx    = tx_end;
  assign nty    = ty_end;

  logic c_last, r_last;
  assign c_last = (c == rx1 - 10'd1);
  assign r_last = (r == ry1 - 10'd1);

  // Divider.
  logic       div_start, div_done;
  logic [7:0] div_q;
  assign div_start = (state == S_DSTART);

  yrm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (cnt),
    .done     (div_done),
    .quotient (div_q)
  );

  // Frame memories.
  logic                 accept, io_addr_ok, io_wr;
  logic [LUMA_AW-1:0]   l_addr;
  logic [CHROMA_AW-1:0] c_addr;
  logic                 l_we, u_we, v_we, filling;
  logic [7:0]           wdata, l_rdata, u_rdata, v_rdata, scan_rdata, io_rdata;

  logic [7:0] luma_mem [LUMA_DEPTH];
  logic [7:0] u_mem    [CHROMA_DEPTH];
  logic [7:0] v_mem    [CHROMA_DEPTH];

  assign in_stall = (state != S_IDLE) || out_valid;
  assign accept   = in_valid && !in_stall;
  assign filling  = (state == S_FILL);

  always_comb begin
    io_addr_ok = 1'b0;
    if (plane == PLANE_Y) begin
      io_addr_ok = (row < 10'(FRAME_HEIGHT)) && (col < 10'(FRAME_WIDTH));
    end else if (plane == PLANE_U || plane == PLANE_V) begin
      io_addr_ok = (row < 10'(CHROMA_H)) && (col < 10'(CHROMA_W));
    end
  end

  assign io_wr  = accept && (req_type == REQ_WRITE) && io_addr_ok;
  assign l_addr = (state == S_IDLE) ? luma_addr(row, col) : luma_addr(r, c);
  assign c_addr = (state == S_IDLE) ? chroma_addr(row, col) : chroma_addr(r, c);
  assign l_we   = (io_wr && plane == PLANE_Y) || (filling && pl == PLANE_Y);
  assign u_we   = (io_wr && plane == PLANE_U) || (filling && pl == PLANE_U);
  assign v_we   = (io_wr && plane == PLANE_V) || (filling && pl == PLANE_V);
  assign wdata  = filling ? (border_mode ? BORDER_LUMA : mean) : sample;

  always_ff @(posedge clk) begin
    if (l_we) begin
      luma_mem[l_addr] <= wdata;
    end
    l_rdata <= luma_mem[l_addr];
  end

  always_ff @(posedge clk) begin
    if (u_we) begin
      u_mem[c_addr] <= wdata;
    end
    u_rdata <= u_mem[c_addr];
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      v_mem[c_addr] <= wdata;
    end
    v_rdata <= v_mem[c_addr];
  end

  always_comb begin
    unique case (pl)
      PLANE_U: scan_rdata = u_rdata;
      PLANE_V: scan_rdata = v_rdata;
      default: scan_rdata = l_rdata;
    endcase
    unique case (rd_pl_q)
      PLANE_U: io_rdata = u_rdata;
      PLANE_V: io_rdata = v_rdata;
      default: io_rdata = l_rdata;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_type == REQ_RUN) begin
            state_next = mosaic_enable ? S_SETUP : S_DONE;
          end else if (req_type == REQ_READ) begin
            state_next = S_RDW;
          end
        end
      end
      S_RDW:    state_next = S_IDLE;
      S_SETUP:  state_next = S_START;
      S_START:  state_next = (w_q == '0 || h_q == '0) ? S_DONE : S_TILE;
      S_TILE:   state_next = S_SUM;
      S_SUM:    state_next = (c_last && r_last) ? S_SUMW : S_SUM;
      S_SUMW:   state_next = S_DSTART;
      S_DSTART: state_next = S_DIV;
      S_DIV:    state_next = div_done ? S_FILL : S_DIV;
      S_FILL: begin
        if (c_last && r_last) begin
          if (!border_mode) begin
            state_next = S_NEXT;
          end else begin
            state_next = (job == 2'd3) ? S_DONE : S_BORD;
          end
        end
      end
      S_NEXT: begin
        if ((job == 2'd0 && chroma_ok) || job == 2'd1) begin
          state_next = S_TILE;
        end else if (ntx < {1'b0, ex_q} || nty < {1'b0, ey_q}) begin
          state_next = S_TILE;
        end else begin
          state_next = (t_q != '0) ? S_BORD : S_DONE;
        end
      end
      S_BORD:   state_next = S_FILL;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      pend        <= 1'b0;
      border_mode <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state == S_SUM);
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept && (req_type == REQ_WRITE || req_type == REQ_NONE)) begin
        out_valid <= 1'b1;
      end
      if (state == S_RDW || state == S_DONE) begin
        out_valid <= 1'b1;
      end
      if (state == S_START) begin
        border_mode <= 1'b0;
      end else if (state == S_BORD) begin
        border_mode <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_ok_q     <= io_addr_ok;
      rd_pl_q     <= plane;
      read_sample <= '0;
      run_done    <= 1'b0;
    end
    if (state == S_RDW) begin
      read_sample <= rd_ok_q ? io_rdata : 8'd0;
    end
    if (state == S_DONE) begin
      run_done <= 1'b1;
    end

    unique case (state)
      S_SETUP: begin
        x_q  <= cx;
        y_q  <= cy;
        w_q  <= cw;
        h_q  <= ch;
        ex_q <= cx + cw;
        ey_q <= cy + ch;
        b_q  <= (tile_size < MIN_TILE) ? MIN_TILE : tile_size;
      end
      S_START: begin
        tx  <= {1'b0, x_q};
        ty  <= {1'b0, y_q};
        job <= 2'd0;
        t_q <= (frame_border == '0) ? 8'd0 :
               (10'(frame_border) < (min_wh >> 2)) ? frame_border : 8'(min_wh >> 2);
      end
      S_TILE: begin
        acc <= '0;
        pl  <= job;
        if (job == 2'd0) begin
          rx0 <= tx[9:0]; ry0 <= ty[9:0]; rx1 <= lx1; ry1 <= ly1;
          r   <= ty[9:0]; c   <= tx[9:0];
        end else begin
          rx0 <= ux; ry0 <= uy; rx1 <= uex; ry1 <= uey;
          r   <= uy; c   <= ux;
        end
      end
      S_SUM, S_FILL: begin
        if (c_last) begin
          c <= rx0;
          r <= r + 10'd1;
        end else begin
          c <= c + 10'd1;
        end
      end
      S_SUMW: begin
        cnt <= CNT_W'(rx1 - rx0) * CNT_W'(ry1 - ry0);
      end
      S_DIV: begin
        mean <= div_q;
        r    <= ry0;
        c    <= rx0;
      end
      S_NEXT: begin
        if ((job == 2'd0 && chroma_ok) || job == 2'd1) begin
          job <= job + 2'd1;
        end else begin
          job <= 2'd0;
          if (ntx < {1'b0, ex_q}) begin
            tx <= ntx;
          end else begin
            tx <= {1'b0, x_q};
            ty <= nty;
          end
        end
      end
      S_BORD: begin
        pl <= PLANE_Y;
        // Top, bottom, left and right bands in that order.
        unique case (job)
          2'd0: begin
            rx0 <= x_q; ry0 <= y_q; rx1 <= ex_q; ry1 <= y_q + 10'(t_q);
            r   <= y_q; c   <= x_q;
          end
          2'd1: begin
            rx0 <= x_q; ry0 <= ey_q - 10'(t_q); rx1 <= ex_q; ry1 <= ey_q;
            r   <= ey_q - 10'(t_q); c <= x_q;
          end
          2'd2: begin
            rx0 <= x_q; ry0 <= y_q; rx1 <= x_q + 10'(t_q); ry1 <= ey_q;
            r   <= y_q; c   <= x_q;
          end
          default: begin
            rx0 <= ex_q - 10'(t_q); ry0 <= y_q; rx1 <= ex_q; ry1 <= ey_q;
            r   <= y_q; c   <= ex_q - 10'(t_q);
          end
        endcase
      end
      default: ;
    endcase

    if (state == S_FILL && border_mode && c_last && r_last) begin
      job <= job + 2'd1;
    end

    if (state == S_SUM || state == S_SUMW) begin
      if (pend) begin
        acc <= acc + SUM_W'(scan_rdata);
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/yrm_div.sv @@
// ----------------------------------------------------------------------------
// yrm_div
// Restoring divider, one quotient bit per cycle, used for the tile means.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module yrm_div
  import yrm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [7:0]       quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  dvd;
  logic [CNT_W-1:0]  dsr;
  logic [CNT_W:0]    rem;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [CNT_W:0]    rem_sh;
  logic              fits;

  assign rem_sh   = {rem[CNT_W-1:0], dvd[SUM_W-1]};
  assign fits     = rem_sh >= {1'b0, dsr};
  assign quotient = dvd[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= !start && busy && (steps == STEP_W'(1));
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(SUM_W);
        dvd   <= dividend;
        dsr   <= divisor;
        rem   <= '0;
      end else if (busy) begin
        rem   <= fits ? rem_sh - {1'b0, dsr} : rem_sh;
        dvd   <= {dvd[SUM_W-2:0], fits};
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/yrm_checker.sv @@
// ----------------------------------------------------------------------------
// yrm_checker
// Port-level checks of the mosaic block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "yuv420_region_mosaic_assert.svh"
module yrm_checker
  import yrm_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] read_sample,
  input logic       run_done
);

  // A stalled result word holds.
  `YRM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(read_sample) && $stable(run_done), "result word changed while stalled")

  // Each accepted word closes the input until its result has gone.
  `YRM_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "input open right after an accepted word")

  // A pending result always blocks the input side.
  `YRM_ASSERT(a_result_blocks, !out_valid || in_stall, "input open while a result waits")

  // A run result carries no sample.
  `YRM_ASSERT(a_run_no_sample, !(out_valid && run_done) || read_sample == 8'd0, "run result with a sample")

endmodule

bind yuv420_region_mosaic yrm_checker u_yrm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .read_sample (read_sample),
  .run_done    (run_done)
);
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the YUV420 region mosaic. Two small windows of the
// frame (top-left and bottom-right corner) are loaded first. The bench then
// mixes sample writes, reads, runs and malformed words under randomly changed
// region settings. A frame model in a scoreboard class predicts every result
// word, which is checked in order.
// ----------------------------------------------------------------------------
module tb_top;
  import yrm_pkg::*;

  localparam logic [1:0] PLANE_NONE = 2'd3;
  localparam int IDLE_LIMIT  = 50000;
  localparam int LONG_HOLD   = 400;
  localparam int PHASES      = 14;
  localparam int PHASE_WORDS = 30;

  typedef struct packed {
    logic [7:0] value;
    logic       done;
  } result_t;

  class mosaic_scoreboard;
    bit [7:0] luma_px [LUMA_DEPTH];
    bit [7:0] u_px [CHROMA_DEPTH];
    bit [7:0] v_px [CHROMA_DEPTH];
    int rx, ry, rw, rh, tile, border, enable;
    result_t pending_results[$];
    int errors, checked, runs_applied;

    function new();
      tile = 16;
    endfunction

    function void set_reg(logic [2:0] idx, logic [9:0] data);
      case (idx)
        CFG_REGION_X:      rx = data;
        CFG_REGION_Y:      ry = data;
        CFG_REGION_WIDTH:  rw = data;
        CFG_REGION_HEIGHT: rh = data;
        CFG_TILE_SIZE:     tile = data[7:0];
        CFG_FRAME_BORDER:  border = data[7:0];
        CFG_MOSAIC_ENABLE: enable = data[0];
        default: ;
      endcase
    endfunction

    function bit [7:0] peek(int pl, int r, int c);
      if (pl == PLANE_Y) return luma_px[r * FRAME_WIDTH + c];
      if (pl == PLANE_U) return u_px[r * CHROMA_W + c];
      return v_px[r * CHROMA_W + c];
    endfunction

    function void poke(int pl, int r, int c, bit [7:0] d);
      if (pl == PLANE_Y) luma_px[r * FRAME_WIDTH + c] = d;
      else if (pl == PLANE_U) u_px[r * CHROMA_W + c] = d;
      else v_px[r * CHROMA_W + c] = d;
    endfunction

    function bit in_frame(int pl, int r, int c);
      if (pl == PLANE_Y) return r < FRAME_HEIGHT && c < FRAME_WIDTH;
      if (pl == PLANE_U || pl == PLANE_V) return r < CHROMA_H && c < CHROMA_W;
      return 0;
    endfunction

    function void average_rect(int pl, int x0, int y0, int x1, int y1);
      int sum, cnt;
      bit [7:0] m;
      sum = 0;
      cnt = (x1 - x0) * (y1 - y0);
      if (cnt <= 0) return;
      for (int r = y0; r < y1; r++)
        for (int c = x0; c < x1; c++) sum += peek(pl, r, c);
      m = sum / cnt;
      for (int r = y0; r < y1; r++)
        for (int c = x0; c < x1; c++) poke(pl, r, c, m);
    endfunction

    function void paint_border(int x0, int y0, int x1, int y1);
      for (int r = y0; r < y1; r++)
        for (int c = x0; c < x1; c++) poke(PLANE_Y, r, c, BORDER_LUMA);
    endfunction

    function void apply_mosaic();
      int x, y, w, h, b, ex, ey, cb, cex, cey, ux, uy, uex, uey, t;
      x = rx < FRAME_WIDTH - 1 ? rx : FRAME_WIDTH - 1;
      y = ry < FRAME_HEIGHT - 1 ? ry : FRAME_HEIGHT - 1;
      w = rw < FRAME_WIDTH - x ? rw : FRAME_WIDTH - x;
      h = rh < FRAME_HEIGHT - y ? rh : FRAME_HEIGHT - y;
      b = tile < 2 ? 2 : tile;
      ex = x + w; ey = y + h; cb = b / 2; cex = ex / 2; cey = ey / 2;
      if (w == 0 || h == 0) return;
      runs_applied++;
      for (int ty = y; ty < ey; ty += b)
        for (int tx = x; tx < ex; tx += b) begin
          ux = tx / 2; uy = ty / 2;
          uex = ux + cb < cex ? ux + cb : cex;
          uey = uy + cb < cey ? uy + cb : cey;
          average_rect(PLANE_Y, tx, ty, tx + b < ex ? tx + b : ex, ty + b < ey ? ty + b : ey);
          if (uex > ux && uey > uy) begin
            average_rect(PLANE_U, ux, uy, uex, uey);
            average_rect(PLANE_V, ux, uy, uex, uey);
          end
        end
      if (border > 0) begin
        t = (w < h ? w : h) / 4;
        if (border < t) t = border;
        if (t > 0) begin
          paint_border(x, y, ex, y + t);
          paint_border(x, ey - t, ex, ey);
          paint_border(x, y, x + t, ey);
          paint_border(ex - t, y, ex, ey);
        end
      end
    endfunction

    // Called for every accepted input word.
    function void note_word(logic [1:0] req, logic [1:0] pl, logic [9:0] r,
                            logic [9:0] c, logic [7:0] s);
      result_t res;
      bit hit;
      res = '0;
      hit = in_frame(pl, r, c);
      case (req)
        REQ_WRITE: if (hit) poke(pl, r, c, s);
        REQ_RUN: begin
          if (enable) apply_mosaic();
          res.done = 1'b1;
        end
        REQ_READ: if (hit) res.value = peek(pl, r, c);
        default: ;
      endcase
      pending_results.push_back(res);
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task check_word(logic [7:0] value, logic done);
      result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing outstanding");
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (value !== want.value)
        report_mismatch($sformatf("read_sample %0h, expected %0h", value, want.value));
      if (done !== want.done)
        report_mismatch($sformatf("run_done %0b, expected %0b", done, want.done));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] req_type = REQ_WRITE;
  logic [1:0] plane = PLANE_Y;
  logic [9:0] row = '0;
  logic [9:0] col = '0;
  logic [7:0] sample = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] read_sample;
  logic       run_done;
  logic       cfg_wen = 1'b0;
  logic [2:0] cfg_index = CFG_REGION_X;
  logic [9:0] cfg_data = '0;

  mosaic_scoreboard sb = new();
  bit no_idle;
  bit long_hold_req;
  int hold_left;
  int idle_cycles;
  int words_sent;

  yuv420_region_mosaic u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .plane(plane), .row(row), .col(col), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_sample(read_sample), .run_done(run_done),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: check each delivered word, then stall a random or long while.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        sb.check_word(read_sample, run_done);
        if (long_hold_req) begin
          hold_left = LONG_HOLD;
          long_hold_req = 0;
        end else begin
          hold_left = no_idle ? 0 : $urandom_range(0, 19);
        end
      end
      out_stall <= hold_left > 0;
      if (hold_left > 0) hold_left--;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wen) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  task send_word(logic [1:0] req, logic [1:0] pl, logic [9:0] r, logic [9:0] c,
                 logic [7:0] s);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req; plane <= pl; row <= r; col <= c; sample <= s;
    do @(posedge clk); while (in_stall);
    sb.note_word(req, pl, r, c, s);
    words_sent++;
  endtask

  task write_reg(logic [2:0] idx, logic [9:0] data);
    cfg_wen <= 1'b1; cfg_index <= idx; cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    cfg_wen <= 1'b0;
  endtask

  // Lets every outstanding result drain before the settings change.
  task drain;
    in_valid <= 1'b0;
    while (sb.pending_results.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Loads one window: 16x16 luma with its 8x8 chroma blocks.
  task load_window(int lr, int lc);
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++)
        send_word(REQ_WRITE, PLANE_Y, lr + r, lc + c, $urandom_range(0, 255));
    for (int pl = PLANE_U; pl <= PLANE_V; pl++)
      for (int r = 0; r < 8; r++)
        for (int c = 0; c < 8; c++)
          send_word(REQ_WRITE, pl, lr / 2 + r, lc / 2 + c, $urandom_range(0, 255));
  endtask

  task write_region(int x, int y, int w, int h, int t, int bd, int en);
    write_reg(CFG_REGION_X, x);
    write_reg(CFG_REGION_Y, y);
    write_reg(CFG_REGION_WIDTH, w);
    write_reg(CFG_REGION_HEIGHT, h);
    write_reg(CFG_TILE_SIZE, t);
    write_reg(CFG_FRAME_BORDER, bd);
    write_reg(CFG_MOSAIC_ENABLE, en);
  endtask

  task random_settings;
    int x, y, w, h, t, bd;
    if ($urandom_range(0, 1)) begin
      x = $urandom_range(0, 15); y = $urandom_range(0, 15);
      w = $urandom_range(0, 16 - x); h = $urandom_range(0, 16 - y);
    end else begin
      // Bottom-right window; coordinates past the frame are clipped by the block.
      x = $urandom_range(0, 1) ? 784 + $urandom_range(0, 15) : $urandom_range(784, 1023);
      y = $urandom_range(0, 1) ? 584 + $urandom_range(0, 15) : $urandom_range(584, 1023);
      w = $urandom_range(0, 1023); h = $urandom_range(0, 1023);
    end
    case ($urandom_range(0, 5))
      0: t = 0;
      1: t = 1;
      2: t = 2;
      3: t = 255;
      4: t = $urandom_range(3, 8);
      default: t = $urandom_range(0, 255);
    endcase
    case ($urandom_range(0, 3))
      0: bd = 0;
      1: bd = 1;
      2: bd = 255;
      default: bd = $urandom_range(0, 8);
    endcase
    write_region(x, y, w, h, t, bd, $urandom_range(0, 5) != 0);
  endtask

  task random_word;
    int kind, pl, base_r, base_c;
    kind = $urandom_range(0, 99);
    pl = $urandom_range(0, 2);
    base_r = $urandom_range(0, 1) ? 584 : 0;
    base_c = base_r == 0 ? 0 : 784;
    if (pl != PLANE_Y) begin
      base_r = base_r / 2; base_c = base_c / 2;
    end
    if (kind < 40) begin
      send_word(REQ_WRITE, pl, base_r + $urandom_range(0, pl == PLANE_Y ? 15 : 7),
                base_c + $urandom_range(0, pl == PLANE_Y ? 15 : 7), $urandom_range(0, 255));
    end else if (kind < 70) begin
      send_word(REQ_READ, pl, base_r + $urandom_range(0, pl == PLANE_Y ? 15 : 7),
                base_c + $urandom_range(0, pl == PLANE_Y ? 15 : 7), $urandom_range(0, 255));
    end else if (kind < 82) begin
      send_word(REQ_RUN, $urandom_range(0, 3), $urandom_range(0, 1023),
                $urandom_range(0, 1023), $urandom_range(0, 255));
    end else if (kind < 88) begin
      send_word(REQ_NONE, $urandom_range(0, 3), $urandom_range(0, 1023),
                $urandom_range(0, 1023), $urandom_range(0, 255));
    end else begin
      // Out-of-frame address or plane 3; never touches an unloaded entry.
      logic [1:0] req;
      req = $urandom_range(0, 1) ? REQ_WRITE : REQ_READ;
      case ($urandom_range(0, 2))
        0: send_word(req, PLANE_NONE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(0, 255));
        1: send_word(req, PLANE_Y, $urandom_range(600, 1023), $urandom_range(0, 1023),
                     $urandom_range(0, 255));
        default: send_word(req, $urandom_range(1, 2), $urandom_range(0, 299),
                           $urandom_range(400, 1023), $urandom_range(0, 255));
      endcase
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    load_window(0, 0);
    load_window(584, 784);

    // Directed words: frame corners, bad addresses, unknown codes, idle runs.
    send_word(REQ_WRITE, PLANE_Y, 599, 799, 8'hFF);
    send_word(REQ_READ, PLANE_Y, 599, 799, 8'h00);
    send_word(REQ_WRITE, PLANE_Y, 0, 0, 8'h00);
    send_word(REQ_READ, PLANE_Y, 0, 0, 8'hFF);
    send_word(REQ_WRITE, PLANE_U, 299, 399, 8'hAA);
    send_word(REQ_READ, PLANE_U, 299, 399, 8'h00);
    send_word(REQ_WRITE, PLANE_V, 0, 0, 8'h55);
    send_word(REQ_READ, PLANE_V, 0, 0, 8'h00);
    send_word(REQ_WRITE, PLANE_Y, 600, 0, 8'h12);
    send_word(REQ_READ, PLANE_Y, 600, 0, 8'h00);
    send_word(REQ_READ, PLANE_Y, 0, 1023, 8'h00);
    send_word(REQ_WRITE, PLANE_V, 300, 400, 8'h34);
    send_word(REQ_WRITE, PLANE_NONE, 1, 1, 8'h56);
    send_word(REQ_READ, PLANE_NONE, 1, 1, 8'h00);
    send_word(REQ_NONE, PLANE_Y, 1023, 1023, 8'hFF);
    send_word(REQ_RUN, PLANE_Y, 0, 0, 8'h00);
    drain();
    write_region(0, 0, 0, 16, 4, 1, 1);
    send_word(REQ_RUN, PLANE_Y, 0, 0, 8'h00);
    send_word(REQ_READ, PLANE_Y, 3, 3, 8'h00);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      no_idle = (p % 4 == 1);
      if (p == 0) write_region(1023, 1023, 1023, 1023, 255, 255, 1);
      else if (p == 1) write_region(0, 0, 16, 16, 0, 1, 1);
      else random_settings();
      if (p == 2) long_hold_req = 1;
      send_word(REQ_RUN, PLANE_Y, 0, 0, 8'h00);
      for (int i = 0; i < PHASE_WORDS; i++) random_word();
    end

    in_valid <= 1'b0;
    while (sb.pending_results.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d words over %0d setting phases, %0d result words checked.",
             words_sent, PHASES + 2, sb.checked);
    $display("Runs that changed the frame: %0d; mismatches: %0d.",
             sb.runs_applied, sb.errors);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
